FILE: rtl/core/tbbe_pkg.sv
// ----------------------------------------------------------------------------
// tbbe_pkg: shared types and constants
// Types, codes and command/status structs shared by the controller, the
// datapath and the top level of the triangular Bernstein basis evaluator.
// ----------------------------------------------------------------------------
package tbbe_pkg;

   localparam int MAX_DEGREE = 15;
   localparam int DEG_W      = 4;
   localparam int WORK_BITS  = 31;
   localparam int WORD_W     = WORK_BITS + 1;

   typedef logic [DEG_W-1:0] idx_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_DEGREE  = 2'd1,
      ERR_OUTSIDE = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      TERM_FIRST,
      TERM_SECOND,
      TERM_THIRD
   } term_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_INIT,
      ST_SCAN,
      ST_RD_SECOND,
      ST_RD_THIRD,
      ST_MUL_THIRD,
      ST_ACC_THIRD,
      ST_WRITE,
      ST_FIN,
      ST_POST
   } state_type;

   typedef struct packed {
      logic     load;
      logic     init_wr;
      term_type rd_term;
      logic     mul_en;
      term_type mul_term;
      logic     mul_keep;
      logic     acc_load;
      logic     acc_add;
      logic     wr_en;
      logic     fin;
      logic     out_load;
      idx_type  idx_a;
      idx_type  idx_b;
      logic     lvl_odd;
   } cmd_type;

   typedef struct packed {
      err_type err;
      idx_type degree;
      idx_type exp_first;
      idx_type exp_second;
      logic    out_free;
   } sts_type;

endpackage

FILE: rtl/core/tbbe_ctrl.sv
// ----------------------------------------------------------------------------
// tbbe_ctrl: recurrence sequencer
// Walks the levels and triangle positions of the recurrence, skips positions
// that cannot reach the requested entry, and steps the datapath through the
// reads, products and write of each entry that is computed.
// ----------------------------------------------------------------------------
module tbbe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tbbe_pkg::sts_type sts,
   output tbbe_pkg::cmd_type cmd
);
   import tbbe_pkg::*;

   state_type  state_ff, state_in;
   idx_type    lvl_ff, lvl_in;
   idx_type    pos_a_ff, pos_a_in;
   idx_type    pos_b_ff, pos_b_in;
   logic [DEG_W:0] ab_sum;
   logic [5:0] sum_lhs, sum_rhs;
   logic       needed, row_end, lvl_end, last_pos, advance;

   always_comb begin
      ab_sum   = {1'b0, pos_a_ff} + {1'b0, pos_b_ff};
      sum_lhs  = {2'b00, lvl_ff} + {2'b00, sts.exp_first} + {2'b00, sts.exp_second};
      sum_rhs  = {2'b00, sts.degree} + {1'b0, ab_sum};
      needed   = (pos_a_ff <= sts.exp_first) && (pos_b_ff <= sts.exp_second) &&
                 (sum_lhs <= sum_rhs);
      row_end  = (ab_sum == {1'b0, lvl_ff});
      lvl_end  = row_end && (pos_a_ff == lvl_ff);
      last_pos = lvl_end && (lvl_ff == sts.degree);
      advance  = ((state_ff == ST_SCAN) && !needed) || (state_ff == ST_WRITE);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = (sts.err != ERR_NONE) ? ST_POST : ST_INIT;
         end
         ST_INIT:      state_in = ST_SCAN;
         ST_SCAN: begin
            priority if (needed) state_in = ST_RD_SECOND;
            else if (last_pos)   state_in = ST_FIN;
            else                 state_in = ST_SCAN;
         end
         ST_RD_SECOND: state_in = ST_RD_THIRD;
         ST_RD_THIRD:  state_in = ST_MUL_THIRD;
         ST_MUL_THIRD: state_in = ST_ACC_THIRD;
         ST_ACC_THIRD: state_in = ST_WRITE;
         ST_WRITE: begin
            state_in = last_pos ? ST_FIN : ST_SCAN;
         end
         ST_FIN:       state_in = ST_POST;
         ST_POST: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      lvl_in   = lvl_ff;
      pos_a_in = pos_a_ff;
      pos_b_in = pos_b_ff;
      priority if (state_ff == ST_INIT) begin
         lvl_in   = idx_type'(1);
         pos_a_in = '0;
         pos_b_in = '0;
      end else if (advance) begin
         priority if (!row_end) begin
            pos_b_in = pos_b_ff + idx_type'(1);
         end else if (!lvl_end) begin
            pos_a_in = pos_a_ff + idx_type'(1);
            pos_b_in = '0;
         end else begin
            lvl_in   = lvl_ff + idx_type'(1);
            pos_a_in = '0;
            pos_b_in = '0;
         end
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.idx_a    = pos_a_ff;
      cmd.idx_b    = pos_b_ff;
      cmd.lvl_odd  = lvl_ff[0];
      cmd.rd_term  = TERM_FIRST;
      cmd.mul_term = TERM_FIRST;
      req_ready    = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE:  cmd.load    = req_valid;
         ST_INIT:  cmd.init_wr = 1'b1;
         ST_SCAN:  cmd.rd_term = TERM_FIRST;
         ST_RD_SECOND: begin
            cmd.rd_term  = TERM_SECOND;
            cmd.mul_en   = 1'b1;
            cmd.mul_term = TERM_FIRST;
            cmd.mul_keep = (pos_a_ff != '0);
         end
         ST_RD_THIRD: begin
            cmd.rd_term  = TERM_THIRD;
            cmd.mul_en   = 1'b1;
            cmd.mul_term = TERM_SECOND;
            cmd.mul_keep = (pos_b_ff != '0);
            cmd.acc_load = 1'b1;
         end
         ST_MUL_THIRD: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_term = TERM_THIRD;
            cmd.mul_keep = !row_end;
            cmd.acc_add  = 1'b1;
         end
         ST_ACC_THIRD: cmd.acc_add  = 1'b1;
         ST_WRITE:     cmd.wr_en    = 1'b1;
         ST_FIN:       cmd.fin      = 1'b1;
         ST_POST:      cmd.out_load = sts.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lvl_ff   <= '0;
         pos_a_ff <= '0;
         pos_b_ff <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
         pos_a_ff <= pos_a_in;
         pos_b_ff <= pos_b_in;
      end
   end

endmodule

FILE: rtl/core/tbbe_dp.sv
// ----------------------------------------------------------------------------
// tbbe_dp: recurrence datapath
// Holds the item, the two level banks of the recurrence in one memory, the
// shared multiplier and accumulator, and the rounding of the result item.
// ----------------------------------------------------------------------------
module tbbe_dp #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [tbbe_pkg::DEG_W-1:0]         req_degree,
   input  logic [tbbe_pkg::DEG_W-1:0]         req_exp_first,
   input  logic [tbbe_pkg::DEG_W-1:0]         req_exp_second,
   input  logic [FRACTION_BITS:0]             req_coord_first,
   input  logic [FRACTION_BITS:0]             req_coord_second,
   input  tbbe_pkg::cmd_type                  cmd,
   output tbbe_pkg::sts_type                  sts,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [FRACTION_BITS:0]             rsp_basis_value,
   output logic signed [FRACTION_BITS+5:0]    rsp_deriv_first,
   output logic signed [FRACTION_BITS+5:0]    rsp_deriv_second,
   output logic [1:0]                         rsp_error_code
);
   import tbbe_pkg::*;

   localparam int COORD_W    = FRACTION_BITS + 1;
   localparam int DERIV_W    = FRACTION_BITS + 6;
   localparam int PROD_W     = COORD_W + WORD_W;
   localparam int DOWN_SHIFT = WORK_BITS - FRACTION_BITS;
   localparam int DIFF_W     = WORD_W + DEG_W + 2;
   localparam int ADDR_W     = 2 * DEG_W + 1;
   localparam int DEPTH      = 2 ** ADDR_W;
   localparam logic [COORD_W:0]    COORD_ONE  = {2'b01, {FRACTION_BITS{1'b0}}};
   localparam logic [WORD_W-1:0]   WORK_ONE   = {1'b1, {WORK_BITS{1'b0}}};
   localparam logic [PROD_W-1:0]   ACC_HALF   = PROD_W'(1) << (FRACTION_BITS - 1);
   localparam logic [WORD_W:0]     BASIS_HALF = (WORD_W + 1)'(1) << (DOWN_SHIFT - 1);
   localparam logic [DIFF_W-1:0]   DERIV_HALF = DIFF_W'(1) << (DOWN_SHIFT - 1);

   function automatic logic signed [DERIV_W-1:0] round_deriv(
      input logic signed [DIFF_W-1:0] x
   );
      logic [DIFF_W-1:0]  mag;
      logic [DIFF_W-1:0]  rsum;
      logic [DERIV_W-1:0] r;
      mag  = x[DIFF_W-1] ? $unsigned(-x) : $unsigned(x);
      rsum = mag + DERIV_HALF;
      r    = rsum[DOWN_SHIFT +: DERIV_W];
      return x[DIFF_W-1] ? $signed(-r) : $signed(r);
   endfunction

   idx_type                    degree_ff, degree_in;
   idx_type                    exp_first_ff, exp_first_in;
   idx_type                    exp_second_ff, exp_second_in;
   logic [COORD_W-1:0]         coord_u_ff, coord_u_in;
   logic [COORD_W-1:0]         coord_v_ff, coord_v_in;
   logic [COORD_W-1:0]         coord_w_ff, coord_w_in;
   err_type                    err_ff, err_in, err_new;
   logic [COORD_W:0]           coord_sum, w_diff;
   logic [DEG_W:0]             exp_sum;

   logic [WORD_W-1:0]          level_mem_ff [DEPTH];
   logic [WORD_W-1:0]          rd_data_ff;
   logic [ADDR_W-1:0]          rd_addr, wr_addr;
   logic                       wr_any;
   logic [WORD_W-1:0]          wr_data;

   logic [WORD_W-1:0]          mul_opnd;
   logic [COORD_W-1:0]         mul_coord;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [WORD_W-1:0]          op_first_ff, op_first_in;
   logic [WORD_W-1:0]          op_second_ff, op_second_in;
   logic [WORD_W-1:0]          op_third_ff, op_third_in;
   logic [PROD_W-1:0]          acc_ff, acc_in, rnd_sum;
   logic [WORD_W-1:0]          rnd_word;
   logic [WORD_W-1:0]          val_ff, val_in;

   logic signed [WORD_W:0]     gap_first, gap_second;
   logic signed [DEG_W:0]      deg_s;
   logic signed [DIFF_W-1:0]   diff_first_ff, diff_first_in;
   logic signed [DIFF_W-1:0]   diff_second_ff, diff_second_in;

   logic [WORD_W:0]            basis_sum;
   logic [COORD_W-1:0]         basis_rnd;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]         basis_ff, basis_in;
   logic signed [DERIV_W-1:0]  dfirst_ff, dfirst_in;
   logic signed [DERIV_W-1:0]  dsecond_ff, dsecond_in;
   err_type                    code_ff, code_in;

   always_comb begin
      exp_sum   = {1'b0, req_exp_first} + {1'b0, req_exp_second};
      coord_sum = {1'b0, req_coord_first} + {1'b0, req_coord_second};
      w_diff    = COORD_ONE - coord_sum;
      priority if (req_degree == '0 || {1'b0, req_degree} > (DEG_W + 1)'(MAX_DEGREE) ||
                   exp_sum > {1'b0, req_degree}) begin
         err_new = ERR_DEGREE;
      end else if (coord_sum > COORD_ONE) begin
         err_new = ERR_OUTSIDE;
      end else begin
         err_new = ERR_NONE;
      end
      degree_in     = cmd.load ? req_degree       : degree_ff;
      exp_first_in  = cmd.load ? req_exp_first    : exp_first_ff;
      exp_second_in = cmd.load ? req_exp_second   : exp_second_ff;
      coord_u_in    = cmd.load ? req_coord_first  : coord_u_ff;
      coord_v_in    = cmd.load ? req_coord_second : coord_v_ff;
      coord_w_in    = cmd.load ? w_diff[COORD_W-1:0] : coord_w_ff;
      err_in        = cmd.load ? err_new          : err_ff;
   end

   assign sts.err        = err_ff;
   assign sts.degree     = degree_ff;
   assign sts.exp_first  = exp_first_ff;
   assign sts.exp_second = exp_second_ff;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (cmd.rd_term)
         TERM_FIRST:  rd_addr = {!cmd.lvl_odd, cmd.idx_a - idx_type'(1), cmd.idx_b};
         TERM_SECOND: rd_addr = {!cmd.lvl_odd, cmd.idx_a, cmd.idx_b - idx_type'(1)};
         TERM_THIRD:  rd_addr = {!cmd.lvl_odd, cmd.idx_a, cmd.idx_b};
         default:     rd_addr = {!cmd.lvl_odd, cmd.idx_a, cmd.idx_b};
      endcase
      wr_any  = cmd.init_wr || cmd.wr_en;
      wr_addr = cmd.init_wr ? '0 : {cmd.lvl_odd, cmd.idx_a, cmd.idx_b};
      wr_data = cmd.init_wr ? WORK_ONE : rnd_word;
   end

   always_ff @(posedge clock) begin
      if (wr_any) begin
         level_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= level_mem_ff[rd_addr];
   end

   always_comb begin
      mul_opnd = cmd.mul_keep ? rd_data_ff : '0;
      unique case (cmd.mul_term)
         TERM_FIRST:  mul_coord = coord_u_ff;
         TERM_SECOND: mul_coord = coord_v_ff;
         TERM_THIRD:  mul_coord = coord_w_ff;
         default:     mul_coord = coord_w_ff;
      endcase
      prod_in      = prod_ff;
      op_first_in  = op_first_ff;
      op_second_in = op_second_ff;
      op_third_in  = op_third_ff;
      if (cmd.mul_en) begin
         prod_in = {{WORD_W{1'b0}}, mul_coord} * {{COORD_W{1'b0}}, mul_opnd};
         unique case (cmd.mul_term)
            TERM_FIRST:  op_first_in  = mul_opnd;
            TERM_SECOND: op_second_in = mul_opnd;
            TERM_THIRD:  op_third_in  = mul_opnd;
            default:     op_third_in  = mul_opnd;
         endcase
      end
   end

   always_comb begin
      priority if (cmd.acc_load) acc_in = prod_ff;
      else if (cmd.acc_add)      acc_in = acc_ff + prod_ff;
      else                       acc_in = acc_ff;
      rnd_sum  = acc_ff + ACC_HALF;
      rnd_word = rnd_sum[FRACTION_BITS +: WORD_W];
      val_in   = cmd.wr_en ? rnd_word : val_ff;
   end

   always_comb begin
      gap_first      = $signed({1'b0, op_first_ff}) - $signed({1'b0, op_third_ff});
      gap_second     = $signed({1'b0, op_second_ff}) - $signed({1'b0, op_third_ff});
      deg_s          = $signed({1'b0, degree_ff});
      diff_first_in  = diff_first_ff;
      diff_second_in = diff_second_ff;
      if (cmd.fin) begin
         diff_first_in  = DIFF_W'(gap_first) * DIFF_W'(deg_s);
         diff_second_in = DIFF_W'(gap_second) * DIFF_W'(deg_s);
      end
   end

   always_comb begin
      basis_sum    = {1'b0, val_ff} + BASIS_HALF;
      basis_rnd    = basis_sum[DOWN_SHIFT +: COORD_W];
      basis_in     = basis_ff;
      dfirst_in    = dfirst_ff;
      dsecond_in   = dsecond_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         code_in      = err_ff;
         if (err_ff == ERR_NONE) begin
            basis_in   = basis_rnd;
            dfirst_in  = round_deriv(diff_first_ff);
            dsecond_in = round_deriv(diff_second_ff);
         end else begin
            basis_in   = '0;
            dfirst_in  = '0;
            dsecond_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      degree_ff      <= degree_in;
      exp_first_ff   <= exp_first_in;
      exp_second_ff  <= exp_second_in;
      coord_u_ff     <= coord_u_in;
      coord_v_ff     <= coord_v_in;
      coord_w_ff     <= coord_w_in;
      err_ff         <= err_in;
      prod_ff        <= prod_in;
      op_first_ff    <= op_first_in;
      op_second_ff   <= op_second_in;
      op_third_ff    <= op_third_in;
      acc_ff         <= acc_in;
      val_ff         <= val_in;
      diff_first_ff  <= diff_first_in;
      diff_second_ff <= diff_second_in;
      basis_ff       <= basis_in;
      dfirst_ff      <= dfirst_in;
      dsecond_ff     <= dsecond_in;
      code_ff        <= code_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_basis_value  = basis_ff;
   assign rsp_deriv_first  = dfirst_ff;
   assign rsp_deriv_second = dsecond_ff;
   assign rsp_error_code   = code_ff;

endmodule

FILE: rtl/core/triangle_bernstein_basis_eval.sv
// ----------------------------------------------------------------------------
// triangle_bernstein_basis_eval: triangular Bernstein basis value and derivatives.
// A rejected item skips the recurrence; else each position is scanned and each needed entry
// is computed on the one shared multiplier. One item is in work at a time, and a new one is
// taken once the last result is loaded; reset empties the result register and idles it.
// ----------------------------------------------------------------------------
module triangle_bernstein_basis_eval #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [3:0]                        req_degree,
   input  logic [3:0]                        req_exp_first,
   input  logic [3:0]                        req_exp_second,
   input  logic [FRACTION_BITS:0]            req_coord_first,
   input  logic [FRACTION_BITS:0]            req_coord_second,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [FRACTION_BITS:0]            rsp_basis_value,
   output logic signed [FRACTION_BITS+5:0]   rsp_deriv_first,
   output logic signed [FRACTION_BITS+5:0]   rsp_deriv_second,
   output logic [1:0]                        rsp_error_code
);
   import tbbe_pkg::*;

   localparam logic [FRACTION_BITS:0] BASIS_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   cmd_type cmd;
   sts_type sts;

   tbbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tbbe_dp #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_degree       (req_degree),
      .req_exp_first    (req_exp_first),
      .req_exp_second   (req_exp_second),
      .req_coord_first  (req_coord_first),
      .req_coord_second (req_coord_second),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_basis_value  (rsp_basis_value),
      .rsp_deriv_first  (rsp_deriv_first),
      .rsp_deriv_second (rsp_deriv_second),
      .rsp_error_code   (rsp_error_code)
   );

`ifndef SYNTH
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("A second item was offered ready while one is in work.");

   a_error_zeroed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_NONE) |->
         (rsp_basis_value == '0) && (rsp_deriv_first == '0) && (rsp_deriv_second == '0))
      else $error("A rejected item carries nonzero result fields.");

   a_basis_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_basis_value <= BASIS_ONE)
      else $error("The basis value exceeds one.");
`endif

endmodule

FILE: tb/sv/tbbe_basis_checker.sv
// ----------------------------------------------------------------------------
// tbbe_basis_checker: result checker for the Bernstein basis evaluator
// Watches the request and response channels. Each accepted item is run
// through a bit-exact de Casteljau predictor. Each response is compared field
// by field with the oldest prediction, and failures and open items are counted.
// ----------------------------------------------------------------------------
module tbbe_basis_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [3:0]         req_degree,
   input  logic [3:0]         req_exp_first,
   input  logic [3:0]         req_exp_second,
   input  logic [16:0]        req_coord_first,
   input  logic [16:0]        req_coord_second,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [16:0]        rsp_basis_value,
   input  logic signed [21:0] rsp_deriv_first,
   input  logic signed [21:0] rsp_deriv_second,
   input  logic [1:0]         rsp_error_code,
   output int                 failures,
   output int                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import tbbe_pkg::*;

   localparam int FRAC     = 16;
   localparam int SHIFT    = WORK_BITS - FRAC;
   localparam longint ONE_Q = 64'd1 << FRAC;

   typedef struct packed {
      logic [16:0]        basis;
      logic signed [21:0] d_first;
      logic signed [21:0] d_second;
      err_type            err;
   } basis_result_type;

   basis_result_type expected_bases[$];

   function automatic logic [63:0] blend3(input logic [63:0] u, input logic [63:0] v,
                                          input logic [63:0] w, input logic [63:0] a,
                                          input logic [63:0] b, input logic [63:0] c);
      logic [63:0] s;
      s = u * a + v * b + w * c;
      return (s + (64'd1 << (WORK_BITS - 1))) >> WORK_BITS;
   endfunction

   function automatic longint round_out(input longint x);
      longint unsigned mag;
      longint unsigned rq;
      mag = (x < 0) ? longint'(-x) : longint'(x);
      rq  = (mag + (64'd1 << (SHIFT - 1))) >> SHIFT;
      return (x < 0) ? -longint'(rq) : longint'(rq);
   endfunction

   function automatic logic signed [21:0] clamp_deriv(input longint x);
      if (x > 2097151) x = 2097151;
      if (x < -2097152) x = -2097152;
      return x[21:0];
   endfunction

   function automatic basis_result_type predict_basis(input logic [3:0] n,
                                                      input logic [3:0] i,
                                                      input logic [3:0] j,
                                                      input logic [16:0] uq,
                                                      input logic [16:0] vq);
      basis_result_type r;
      logic [63:0] u, v, w, pa, pb, pc, val, ta, tb, tc;
      logic [63:0] cur [16][16];
      logic [63:0] nxt [16][16];
      longint du, dv, bo;
      int ni, ii, jj, kk, m, a, b;
      r = '0;
      ni = int'(n);
      ii = int'(i);
      jj = int'(j);
      if (ni == 0 || ii + jj > ni) begin
         r.err = ERR_DEGREE;
         return r;
      end
      if (longint'(uq) + longint'(vq) > ONE_Q) begin
         r.err = ERR_OUTSIDE;
         return r;
      end
      kk = ni - ii - jj;
      u = 64'(uq) << SHIFT;
      v = 64'(vq) << SHIFT;
      w = (64'd1 << WORK_BITS) - u - v;
      for (a = 0; a < 16; a++)
         for (b = 0; b < 16; b++)
            cur[a][b] = '0;
      cur[0][0] = 64'd1 << WORK_BITS;
      for (m = 1; m < ni; m++) begin
         for (a = 0; a < 16; a++)
            for (b = 0; b < 16; b++)
               nxt[a][b] = '0;
         for (a = 0; a <= m; a++) begin
            for (b = 0; a + b <= m; b++) begin
               ta = (a > 0) ? cur[a-1][b] : 64'd0;
               tb = (b > 0) ? cur[a][b-1] : 64'd0;
               tc = (a + b < m) ? cur[a][b] : 64'd0;
               nxt[a][b] = blend3(u, v, w, ta, tb, tc);
            end
         end
         cur = nxt;
      end
      pa = (ii > 0) ? cur[ii-1][jj] : 64'd0;
      pb = (jj > 0) ? cur[ii][jj-1] : 64'd0;
      pc = (kk > 0) ? cur[ii][jj] : 64'd0;
      val = blend3(u, v, w, pa, pb, pc);
      du = longint'(ni) * (longint'(pa) - longint'(pc));
      dv = longint'(ni) * (longint'(pb) - longint'(pc));
      bo = round_out(longint'(val));
      if (bo > 131071) bo = 131071;
      r.basis    = bo[16:0];
      r.d_first  = clamp_deriv(round_out(du));
      r.d_second = clamp_deriv(round_out(dv));
      r.err      = ERR_NONE;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      basis_result_type want;
      if (reset) begin
         expected_bases.delete();
         outstanding <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_bases.push_back(predict_basis(req_degree, req_exp_first,
                                                   req_exp_second, req_coord_first,
                                                   req_coord_second));
         if (rsp_valid && rsp_ready) begin
            if (expected_bases.size() == 0) begin
               if (failures < 10)
                  $display("%0t: result item with nothing expected", $realtime);
               failures = failures + 1;
            end else begin
               want = expected_bases.pop_front();
               if (rsp_basis_value !== want.basis || rsp_deriv_first !== want.d_first ||
                   rsp_deriv_second !== want.d_second || rsp_error_code !== want.err) begin
                  if (failures < 10)
                     $display("%0t: mismatch, exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                              $realtime, want.basis, want.d_first, want.d_second, want.err,
                              rsp_basis_value, rsp_deriv_first, rsp_deriv_second,
                              rsp_error_code);
                  failures = failures + 1;
               end
            end
         end
         outstanding <= expected_bases.size();
      end
   end

endmodule

FILE: tb/sv/tb_triangle_bernstein_basis_eval.sv
// ----------------------------------------------------------------------------
// tb_triangle_bernstein_basis_eval: testbench top for the basis evaluator
// Drives directed corner items and then mostly well-formed random items with
// random idling on both channels, a long response hold-off and a drain pause.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_triangle_bernstein_basis_eval;
   timeunit 1ns;
   timeprecision 1ps;

   import tbbe_pkg::*;

   localparam int IDLE_LIMIT = 40000;
   localparam int HOLD_CYCLES = 400;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [3:0]         req_degree;
   logic [3:0]         req_exp_first;
   logic [3:0]         req_exp_second;
   logic [16:0]        req_coord_first;
   logic [16:0]        req_coord_second;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [16:0]        rsp_basis_value;
   logic signed [21:0] rsp_deriv_first;
   logic signed [21:0] rsp_deriv_second;
   logic [1:0]         rsp_error_code;

   int  failures;
   int  outstanding;
   int  quiet_cycles;
   int  gap_odds;
   int  hold_requests;
   int  holds_done;
   bit  calm;

   triangle_bernstein_basis_eval DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_degree       (req_degree),
      .req_exp_first    (req_exp_first),
      .req_exp_second   (req_exp_second),
      .req_coord_first  (req_coord_first),
      .req_coord_second (req_coord_second),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_basis_value  (rsp_basis_value),
      .rsp_deriv_first  (rsp_deriv_first),
      .rsp_deriv_second (rsp_deriv_second),
      .rsp_error_code   (rsp_error_code)
   );

   tbbe_basis_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_degree       (req_degree),
      .req_exp_first    (req_exp_first),
      .req_exp_second   (req_exp_second),
      .req_coord_first  (req_coord_first),
      .req_coord_second (req_coord_second),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_basis_value  (rsp_basis_value),
      .rsp_deriv_first  (rsp_deriv_first),
      .rsp_deriv_second (rsp_deriv_second),
      .rsp_error_code   (rsp_error_code),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_triangle_bernstein_basis_eval: errors");
            $finish;
         end
      end
   end

   initial begin : response_side
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_done != hold_requests) begin
            holds_done = holds_done + 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (calm || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   task automatic send_item(input logic [3:0] n, input logic [3:0] i, input logic [3:0] j,
                            input logic [16:0] u, input logic [16:0] v);
      bit taken;
      req_valid        <= 1'b1;
      req_degree       <= n;
      req_exp_first    <= i;
      req_exp_second   <= j;
      req_coord_first  <= u;
      req_coord_second <= v;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      if (!calm && gap_odds != 0 && $urandom_range(1, 8) <= gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic send_random_item();
      logic [3:0]  n, i, j;
      logic [16:0] u, v;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) n = 4'($urandom_range(1, 5));
      else if (pick < 92) n = 4'($urandom_range(6, 10));
      else n = 4'($urandom_range(11, 15));
      if ($urandom_range(0, 99) < 88) begin
         i = 4'($urandom_range(0, n));
         j = 4'($urandom_range(0, n - i));
      end else begin
         i = 4'($urandom);
         j = 4'($urandom);
         if ($urandom_range(0, 3) == 0) n = '0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         u = 17'($urandom_range(0, 65536));
         v = 17'($urandom_range(0, 65536 - u));
      end else if (pick < 85) begin
         u = 17'($urandom_range(0, 65536));
         v = 17'(65536 - u);
      end else if (pick < 90) begin
         u = ($urandom_range(0, 1) != 0) ? 17'd65536 : 17'd0;
         v = '0;
      end else begin
         u = 17'($urandom);
         v = 17'($urandom);
      end
      if ($urandom_range(0, 1) != 0) send_item(n, i, j, u, v);
      else send_item(n, j, i, v, u);
   endtask

   task automatic drain();
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   initial begin : request_side
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_degree       = '0;
      req_exp_first    = '0;
      req_exp_second   = '0;
      req_coord_first  = '0;
      req_coord_second = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_odds = 2;
      send_item(4'd1, 4'd0, 4'd0, 17'd0, 17'd0);
      send_item(4'd1, 4'd1, 4'd0, 17'd65536, 17'd0);
      send_item(4'd1, 4'd0, 4'd1, 17'd0, 17'd65536);
      send_item(4'd2, 4'd1, 4'd1, 17'd32768, 17'd32768);
      send_item(4'd15, 4'd15, 4'd0, 17'd65536, 17'd0);
      send_item(4'd15, 4'd0, 4'd15, 17'd0, 17'd65536);
      send_item(4'd15, 4'd0, 4'd0, 17'd0, 17'd0);
      send_item(4'd15, 4'd5, 4'd5, 17'd21845, 17'd21845);
      send_item(4'd15, 4'd7, 4'd3, 17'd1, 17'd65534);
      send_item(4'd0, 4'd0, 4'd0, 17'd100, 17'd200);
      send_item(4'd0, 4'd0, 4'd0, 17'd131071, 17'd131071);
      send_item(4'd3, 4'd2, 4'd2, 17'd1000, 17'd1000);
      send_item(4'd15, 4'd15, 4'd15, 17'd0, 17'd0);
      send_item(4'd4, 4'd1, 4'd1, 17'd65536, 17'd1);
      send_item(4'd4, 4'd1, 4'd1, 17'd131071, 17'd0);
      send_item(4'd4, 4'd1, 4'd1, 17'd0, 17'd131071);
      send_item(4'd4, 4'd1, 4'd2, 17'd32768, 17'd32768);
      send_item(4'd6, 4'd0, 4'd3, 17'd20000, 17'd30000);
      send_item(4'd6, 4'd3, 4'd0, 17'd20000, 17'd30000);
      send_item(4'd6, 4'd3, 4'd3, 17'd20000, 17'd30000);
      send_item(4'd5, 4'd2, 4'd1, 17'd65535, 17'd1);
      send_item(4'd8, 4'd0, 4'd0, 17'd43690, 17'd0);

      for (int c = 0; c < 900; c++) begin
         if (c % 100 == 0) gap_odds = $urandom_range(0, 3);
         send_random_item();
      end

      req_valid <= 1'b0;
      drain();
      hold_requests = hold_requests + 1;
      gap_odds      = 0;
      for (int c = 0; c < 40; c++)
         send_item(4'($urandom_range(1, 4)), 4'd0, 4'd1, 17'($urandom_range(0, 30000)),
                   17'($urandom_range(0, 30000)));

      for (int c = 0; c < 740; c++) begin
         if (c % 100 == 0) gap_odds = $urandom_range(0, 3);
         send_random_item();
      end

      calm = 1'b1;
      for (int c = 0; c < 120; c++)
         send_random_item();
      req_valid <= 1'b0;

      do @(negedge clock); while (outstanding != 0);
      repeat (50) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("tb_triangle_bernstein_basis_eval: clean");
      end else begin
         $display("tb_triangle_bernstein_basis_eval: errors");
      end
      $finish;
   end

endmodule
